### rtl/core/paw_pkg.sv
// Shared widths and constants for the polygon area block.
`timescale 1ns / 1ps

package paw_pkg;

  // Width of one vertex coordinate.
  localparam int CRD_W = 24;

  // Width of one coordinate product.
  localparam int PROD_W = 2 * CRD_W;

  // Width of one cross-product term (difference of two products).
  localparam int TERM_W = PROD_W + 1;

  // Width of the ring and polygon accumulators and of the result.
  localparam int ACC_W = 64;

  // Largest and smallest accumulator values.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};

endpackage

### rtl/core/polygon_area_with_holes.sv
// Streaming shoelace area of a polygon with holes, one vertex per cycle unless stalled.
`timescale 1ns / 1ps

// Usage:
//   Vertices enter on the vtx channel (vtx_valid / vtx_stall) as signed x_coord,
//   y_coord with ring_end on the closing vertex of each ring and poly_end on the
//   last vertex of the polygon (poly_end also closes the ring). Rings are given
//   closed. The first ring is the outer ring; every later ring is a hole.
//   One result per polygon leaves on the area channel (area_valid / area_stall):
//   twice_area, twice the outer area minus twice the hole areas, exact and
//   saturated to signed 64 bits.
//   Throughput: one vertex per cycle while vtx_stall is low. After the poly_end
//   vertex is transferred, the result passes through the five register stages
//   (input, products, term, ring sum, magnitude) ahead of the result register.
//   A stalled result holds in the result register while vertices keep flowing;
//   vtx_stall rises only when the next result reaches the last stage while the
//   held one is still stalled.
//   Reset clears all pipeline valid bits, the ring and polygon accumulators,
//   and marks the next vertex as the start of an outer ring.
module polygon_area_with_holes (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vtx_valid,
  output logic                               vtx_stall,
  input  logic signed [paw_pkg::CRD_W-1:0]   x_coord,
  input  logic signed [paw_pkg::CRD_W-1:0]   y_coord,
  input  logic                               ring_end,
  input  logic                               poly_end,
  output logic                               area_valid,
  input  logic                               area_stall,
  output logic signed [paw_pkg::ACC_W-1:0]   twice_area
);

  // Saturating signed add.
  function automatic logic signed [paw_pkg::ACC_W-1:0] sat_add(
    input logic signed [paw_pkg::ACC_W-1:0] a,
    input logic signed [paw_pkg::ACC_W-1:0] b
  );
    logic signed [paw_pkg::ACC_W-1:0] sum;
    sum = a + b;
    if ((a[paw_pkg::ACC_W-1] == b[paw_pkg::ACC_W-1]) &&
        (sum[paw_pkg::ACC_W-1] != a[paw_pkg::ACC_W-1])) begin
      sum = a[paw_pkg::ACC_W-1] ? paw_pkg::ACC_MIN : paw_pkg::ACC_MAX;
    end
    return sum;
  endfunction

  // Magnitude with the most negative value mapped to the largest positive one.
  function automatic logic signed [paw_pkg::ACC_W-1:0] sat_abs(
    input logic signed [paw_pkg::ACC_W-1:0] a
  );
    logic signed [paw_pkg::ACC_W-1:0] mag;
    if (a == paw_pkg::ACC_MIN) begin
      mag = paw_pkg::ACC_MAX;
    end else if (a[paw_pkg::ACC_W-1]) begin
      mag = -a;
    end else begin
      mag = a;
    end
    return mag;
  endfunction

  // Stage registers.
  logic                               s0_valid, s1_valid, s2_valid, s3_valid, s4_valid;
  logic                               s0_first, s0_rend, s0_pend;
  logic                               s1_rend, s1_pend;
  logic                               s2_rend, s2_pend;
  logic                               s3_rend, s3_pend;
  logic                               s4_rend, s4_pend;
  logic signed [paw_pkg::CRD_W-1:0]   s0_x, s0_y, s0_px, s0_py;
  logic signed [paw_pkg::PROD_W-1:0]  s1_p1, s1_p2;
  logic signed [paw_pkg::TERM_W-1:0]  s2_term;
  logic signed [paw_pkg::ACC_W-1:0]   s3_sum;
  logic signed [paw_pkg::ACC_W-1:0]   s4_mag;

  // Running state.
  logic signed [paw_pkg::CRD_W-1:0]   prev_x, prev_y;
  logic                               ring_start;
  logic signed [paw_pkg::ACC_W-1:0]   ring_sum, ring_sum_next;
  logic signed [paw_pkg::ACC_W-1:0]   poly_acc, poly_acc_next;
  logic                               outer_pending;

  logic                               advance;
  logic                               vtx_xfer;
  logic signed [paw_pkg::PROD_W-1:0]  prod_a, prod_b;

  // The pipeline holds only when a new result must enter a stalled result register.
  assign advance   = !(s4_valid && s4_pend && area_valid && area_stall);
  assign vtx_stall = !advance;
  assign vtx_xfer  = vtx_valid && advance;

  // Cross products of the stored previous vertex and the current vertex.
  assign prod_a = s0_px * s0_y;
  assign prod_b = s0_x * s0_py;

  // Ring accumulation with saturation at every term.
  assign ring_sum_next = sat_add(ring_sum, paw_pkg::ACC_W'(s2_term));

  // Outer ring replaces the total; holes subtract their magnitude.
  assign poly_acc_next = outer_pending ? s4_mag : sat_add(poly_acc, -s4_mag);

  // Control state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      area_valid    <= 1'b0;
      ring_start    <= 1'b1;
      ring_sum      <= '0;
      poly_acc      <= '0;
      outer_pending <= 1'b1;
    end else begin
      if (area_valid && !area_stall) begin
        area_valid <= 1'b0;
      end
      if (advance) begin
        s0_valid <= vtx_xfer;
        s1_valid <= s0_valid;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        s4_valid <= s3_valid;
        if (vtx_xfer) begin
          ring_start <= ring_end || poly_end;
        end
        if (s2_valid) begin
          ring_sum <= s2_rend ? '0 : ring_sum_next;
        end
        if (s4_valid && s4_rend) begin
          if (s4_pend) begin
            poly_acc      <= '0;
            outer_pending <= 1'b1;
            area_valid    <= 1'b1;
          end else begin
            poly_acc      <= poly_acc_next;
            outer_pending <= 1'b0;
          end
        end
      end
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (vtx_xfer) begin
        s0_x     <= x_coord;
        s0_y     <= y_coord;
        s0_px    <= prev_x;
        s0_py    <= prev_y;
        s0_first <= ring_start;
        s0_rend  <= ring_end || poly_end;
        s0_pend  <= poly_end;
        prev_x   <= x_coord;
        prev_y   <= y_coord;
      end
      s1_p1   <= s0_first ? '0 : prod_a;
      s1_p2   <= s0_first ? '0 : prod_b;
      s1_rend <= s0_rend;
      s1_pend <= s0_pend;
      s2_term <= paw_pkg::TERM_W'(s1_p1) - paw_pkg::TERM_W'(s1_p2);
      s2_rend <= s1_rend;
      s2_pend <= s1_pend;
      s3_sum  <= ring_sum_next;
      s3_rend <= s2_rend;
      s3_pend <= s2_pend;
      s4_mag  <= sat_abs(s3_sum);
      s4_rend <= s3_rend;
      s4_pend <= s3_pend;
      if (s4_valid && s4_pend) begin
        twice_area <= poly_acc_next;
      end
    end
  end

endmodule

### rtl/core/paw_checker.sv
// Port-level checker for the polygon area block and its bind.
`timescale 1ns / 1ps

module paw_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             vtx_valid,
  input logic                             vtx_stall,
  input logic signed [paw_pkg::CRD_W-1:0] x_coord,
  input logic signed [paw_pkg::CRD_W-1:0] y_coord,
  input logic                             ring_end,
  input logic                             poly_end,
  input logic                             area_valid,
  input logic                             area_stall,
  input logic signed [paw_pkg::ACC_W-1:0] twice_area
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    area_valid && area_stall |=> area_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    area_valid && area_stall |=> $stable(twice_area))
    else $error("result changed while stalled");

  // Reset leaves no result on the output.
  assert property (@(posedge clk)
    rst |=> !area_valid)
    else $error("result valid after reset");

  // Vertex input is held off only behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> area_valid && area_stall)
    else $error("vertex input stalled without output back-pressure");

  // A stalled vertex stays offered with the same payload.
  assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_stall |=> vtx_valid && $stable(x_coord) && $stable(y_coord) &&
                               $stable(ring_end) && $stable(poly_end))
    else $error("vertex changed while stalled");

endmodule

bind polygon_area_with_holes paw_checker u_paw_checker (
  .clk        (clk),
  .rst        (rst),
  .vtx_valid  (vtx_valid),
  .vtx_stall  (vtx_stall),
  .x_coord    (x_coord),
  .y_coord    (y_coord),
  .ring_end   (ring_end),
  .poly_end   (poly_end),
  .area_valid (area_valid),
  .area_stall (area_stall),
  .twice_area (twice_area)
);

### tb/sv/polygon_area_with_holes_tb.sv
// Self-checking testbench for the streaming polygon area block.
`timescale 1ns / 1ps

module polygon_area_with_holes_tb;

  localparam int CRD_W = paw_pkg::CRD_W;
  localparam int ACC_W = paw_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = paw_pkg::ACC_MAX;
  localparam logic signed [ACC_W-1:0] ACC_MIN = paw_pkg::ACC_MIN;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int BIG_LOOPS = 4;
  localparam int DRAIN_CYCLES = 20;

  localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W - 1){1'b0}}};
  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W - 1){1'b1}}};

  typedef struct {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic                    re;
    logic                    pe;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    vtx_valid = 1'b0;
  logic                    vtx_stall;
  logic signed [CRD_W-1:0] x_coord = '0;
  logic signed [CRD_W-1:0] y_coord = '0;
  logic                    ring_end = 1'b0;
  logic                    poly_end = 1'b0;
  logic                    area_valid;
  logic                    area_stall = 1'b0;
  logic signed [ACC_W-1:0] twice_area;

  // Vertices waiting to be driven and areas waiting to come out.
  vertex_t                 pending_vtx[$];
  logic signed [ACC_W-1:0] expected_area[$];

  int vertices_queued = 0;
  int vertices_accepted = 0;
  int polygons_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shoelace state of the predictor.
  logic signed [CRD_W-1:0] last_x = '0;
  logic signed [CRD_W-1:0] last_y = '0;
  logic                    ring_fresh = 1'b1;
  logic signed [ACC_W-1:0] ring_cross = '0;
  logic signed [ACC_W-1:0] poly_total = '0;
  logic                    outer_next = 1'b1;

  polygon_area_with_holes u_top (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .ring_end  (ring_end),
    .poly_end  (poly_end),
    .area_valid(area_valid),
    .area_stall(area_stall),
    .twice_area(twice_area)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed 64-bit addition that clamps instead of wrapping.
  function automatic logic signed [ACC_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // Advance the predicted area state by one transferred vertex.
  task automatic shoelace_step(input logic signed [CRD_W-1:0] x, input logic signed [CRD_W-1:0] y,
                               input logic re, input logic pe);
    longint                  term;
    logic signed [ACC_W-1:0] mag;
    if (ring_fresh) begin
      ring_fresh = 1'b0;
    end else begin
      term = longint'(last_x) * longint'(y) - longint'(x) * longint'(last_y);
      ring_cross = sat_sum(ring_cross, term);
    end
    last_x = x;
    last_y = y;
    // A closed ring sets the total if it is the outer one, else it is a hole.
    if (re || pe) begin
      if (ring_cross == ACC_MIN) begin
        mag = ACC_MAX;
      end else begin
        mag = (ring_cross < 0) ? -ring_cross : ring_cross;
      end
      if (outer_next) begin
        poly_total = mag;
        outer_next = 1'b0;
      end else begin
        poly_total = sat_sum(poly_total, -mag);
      end
      ring_cross = '0;
      ring_fresh = 1'b1;
    end
    if (pe) begin
      expected_area.push_back(poly_total);
      poly_total = '0;
      outer_next = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [ACC_W-1:0] got,
                                 input logic signed [ACC_W-1:0] want);
    $display("MISMATCH polygon %0d: %s: got %0d, expected %0d", polygons_checked, what, got, want);
    fail_count++;
  endtask

  // Coordinates arrive as int and keep their low CRD_W bits.
  task automatic push_vtx(input int x, input int y, input logic re, input logic pe);
    vertex_t v;
    v.x = x[CRD_W-1:0];
    v.y = y[CRD_W-1:0];
    v.re = re;
    v.pe = pe;
    pending_vtx.push_back(v);
    vertices_queued++;
  endtask

  // Random coordinate at one of several magnitudes.
  function automatic logic signed [CRD_W-1:0] rand_coord(input int scale);
    int v;
    case (scale)
      0: v = int'($urandom_range(200)) - 100;
      1: v = int'($urandom_range(65535)) - 32768;
      2: v = $urandom;
      default: begin
        case ($urandom_range(3))
          0: v = int'(CRD_MIN);
          1: v = int'(CRD_MAX);
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[CRD_W-1:0];
  endfunction

  // Polygon of one to three rings; most rings closed, some left open or single.
  task automatic add_random_polygon();
    int                      n_rings;
    int                      n_pts;
    int                      scale;
    bit                      closed;
    bit                      last_ring;
    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] y0;
    vertex_t                 ring_q[$];
    vertex_t                 v;
    n_rings = $urandom_range(1, 3);
    for (int r = 0; r < n_rings; r++) begin
      last_ring = (r == n_rings - 1);
      n_pts = $urandom_range(1, 8);
      scale = $urandom_range(3);
      closed = ($urandom_range(9) != 0);
      ring_q.delete();
      for (int i = 0; i < n_pts; i++) begin
        v.x = rand_coord(scale);
        v.y = rand_coord(scale);
        v.re = 1'b0;
        v.pe = 1'b0;
        if (i == 0) begin
          x0 = v.x;
          y0 = v.y;
        end
        ring_q.push_back(v);
      end
      if (closed && n_pts > 1) begin
        v.x = x0;
        v.y = y0;
        ring_q.push_back(v);
      end
      // The polygon mark closes the ring on its own, so ring_end is optional there.
      ring_q[$].pe = last_ring;
      ring_q[$].re = last_ring ? 1'($urandom_range(1)) : 1'b1;
      foreach (ring_q[i]) begin
        push_vtx(int'(ring_q[i].x), int'(ring_q[i].y), ring_q[i].re, ring_q[i].pe);
      end
    end
  endtask

  // A few laps around the full-range square for large ring sums.
  task automatic add_square_laps(input bit clockwise);
    logic signed [CRD_W-1:0] cx[4];
    logic signed [CRD_W-1:0] cy[4];
    int                      idx;
    cx = '{CRD_MIN, CRD_MAX, CRD_MAX, CRD_MIN};
    cy = '{CRD_MIN, CRD_MIN, CRD_MAX, CRD_MAX};
    for (int l = 0; l < BIG_LOOPS; l++) begin
      for (int c = 0; c < 4; c++) begin
        idx = clockwise ? 3 - c : c;
        push_vtx(int'(cx[idx]), int'(cy[idx]), 1'b0, 1'b0);
      end
    end
  endtask

  task automatic wait_drained();
    while (vertices_accepted < vertices_queued || expected_area.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic start_phase(input int idle_pct, input int stall_pct);
    @(negedge clk);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic add_random_phase();
    int start_count;
    @(negedge clk);
    start_count = vertices_queued;
    while (vertices_queued - start_count < RANDOM_PER_PHASE) add_random_polygon();
  endtask

  // Vertex driver: predicts on each transfer, then offers the next vertex or idles.
  always @(posedge clk) begin : drive_vtx
    vertex_t nxt;
    if (rst) begin
      vtx_valid <= 1'b0;
    end else begin
      if (vtx_valid && !vtx_stall) begin
        shoelace_step(x_coord, y_coord, ring_end, poly_end);
        vertices_accepted++;
      end
      if (!vtx_valid || !vtx_stall) begin
        if (pending_vtx.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_vtx.pop_front();
          x_coord <= nxt.x;
          y_coord <= nxt.y;
          ring_end <= nxt.re;
          poly_end <= nxt.pe;
          vtx_valid <= 1'b1;
        end else begin
          vtx_valid <= 1'b0;
        end
      end
    end
  end

  // Area monitor: checks each transfer against the oldest prediction.
  always @(posedge clk) begin : check_area
    logic signed [ACC_W-1:0] want;
    if (rst) begin
      area_stall <= 1'b0;
    end else begin
      if (area_valid && !area_stall) begin
        if (expected_area.size() == 0) begin
          report_mismatch("area with no polygon pending", twice_area, '0);
        end else begin
          want = expected_area.pop_front();
          if (twice_area !== want) begin
            report_mismatch("twice_area", twice_area, want);
          end
        end
        polygons_checked++;
      end
      area_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // Directed polygons: a square, a square with a hole, a lone vertex,
    // a hole larger than its outer ring, and a ring left open.
    push_vtx(0, 0, 1'b0, 1'b0);
    push_vtx(4, 0, 1'b0, 1'b0);
    push_vtx(4, 4, 1'b0, 1'b0);
    push_vtx(0, 4, 1'b0, 1'b0);
    push_vtx(0, 0, 1'b1, 1'b1);

    push_vtx(0, 0, 1'b0, 1'b0);
    push_vtx(10, 0, 1'b0, 1'b0);
    push_vtx(10, 10, 1'b0, 1'b0);
    push_vtx(0, 10, 1'b0, 1'b0);
    push_vtx(0, 0, 1'b1, 1'b0);
    push_vtx(2, 2, 1'b0, 1'b0);
    push_vtx(2, 4, 1'b0, 1'b0);
    push_vtx(4, 4, 1'b0, 1'b0);
    push_vtx(4, 2, 1'b0, 1'b0);
    push_vtx(2, 2, 1'b0, 1'b1);

    push_vtx(5, -7, 1'b0, 1'b1);

    push_vtx(int'(CRD_MAX), int'(CRD_MIN), 1'b1, 1'b0);
    push_vtx(-3, -3, 1'b0, 1'b0);
    push_vtx(6, -3, 1'b0, 1'b0);
    push_vtx(-3, 6, 1'b0, 1'b0);
    push_vtx(-3, -3, 1'b1, 1'b1);

    push_vtx(0, 0, 1'b0, 1'b0);
    push_vtx(3, 0, 1'b0, 1'b0);
    push_vtx(0, 3, 1'b1, 1'b1);

    // Outer ring with a large positive sum, then a few reversed edges.
    add_square_laps(1'b0);
    push_vtx(int'(CRD_MAX), int'(CRD_MAX), 1'b0, 1'b0);
    push_vtx(int'(CRD_MAX), int'(CRD_MIN), 1'b0, 1'b0);
    push_vtx(int'(CRD_MIN), int'(CRD_MIN), 1'b1, 1'b1);

    // Unit outer ring, a large clockwise hole, and a small hole after it.
    push_vtx(0, 0, 1'b0, 1'b0);
    push_vtx(1, 0, 1'b0, 1'b0);
    push_vtx(1, 1, 1'b0, 1'b0);
    push_vtx(0, 1, 1'b0, 1'b0);
    push_vtx(0, 0, 1'b1, 1'b0);
    add_square_laps(1'b1);
    push_vtx(int'(CRD_MIN), int'(CRD_MIN), 1'b1, 1'b0);
    push_vtx(0, 0, 1'b0, 1'b0);
    push_vtx(2, 0, 1'b0, 1'b0);
    push_vtx(2, 2, 1'b0, 1'b0);
    push_vtx(0, 0, 1'b1, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs at full rate; each later phase waits for all areas.
    wait_drained();
    add_random_phase();
    wait_drained();
    start_phase(88, 0);
    add_random_phase();
    wait_drained();
    start_phase(0, 88);
    add_random_phase();
    wait_drained();
    start_phase(30, 30);
    add_random_phase();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
